// ===== sv/lbo_pkg.sv =====
// Package with shared types and constants for the LED blink one-shot controller.
`timescale 1ns / 1ps

package lbo_pkg;

    // Number of lamps in the row and the width of the lamp state field.
    localparam int NUM_LAMPS   = 11;
    localparam int LAMP_W      = 11;
    localparam int LAMP_IDX_W  = 4;

    // Time and configuration widths.
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] ONESHOT_MS_RST     = 16'd50;
    localparam logic [CFG_W-1:0] HALF_PERIOD_MS_RST = 16'd250;

    // Register indexes (byte address divided by four).
    localparam logic REG_ONESHOT_MS     = 1'b0;
    localparam logic REG_HALF_PERIOD_MS = 1'b1;

    // Command codes.
    typedef enum logic [1:0] {
        FUNC_ON    = 2'd0,
        FUNC_OFF   = 2'd1,
        FUNC_BLINK = 2'd2,
        FUNC_TICK  = 2'd3
    } func_t;

    // One command request as held in the input register.
    typedef struct packed {
        func_t                  func;
        logic [LAMP_IDX_W-1:0]  lamp_index;
        logic                   oneshot;
    } cmd_t;

    // Configuration values handed to the lamp core.
    typedef struct packed {
        logic [CFG_W-1:0] oneshot_ms;
        logic [CFG_W-1:0] half_period_ms;
    } cfg_t;

endpackage

// ===== sv/lbo_if.sv =====
// Valid/ready interfaces for the command and lamp state channels.
`timescale 1ns / 1ps

interface lbo_cmd_if;
    import lbo_pkg::*;

    logic                  valid;
    logic                  ready;
    func_t                 func;
    logic [LAMP_IDX_W-1:0] lamp_index;
    logic                  oneshot;

    modport source (output valid, output func, output lamp_index, output oneshot,
                    input ready);
    modport sink   (input valid, input func, input lamp_index, input oneshot,
                    output ready);
endinterface

interface lbo_res_if;
    import lbo_pkg::*;

    logic              valid;
    logic              ready;
    logic [LAMP_W-1:0] lamp_states;

    modport source (output valid, output lamp_states, input ready);
    modport sink   (input valid, input lamp_states, output ready);
endinterface

// ===== sv/lbo_apb_regs.sv =====
// APB configuration registers: one-shot time and blink half period.
`timescale 1ns / 1ps

module lbo_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lbo_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lbo_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lbo_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output lbo_pkg::cfg_t                    cfg
);
    import lbo_pkg::*;

    logic [CFG_W-1:0] oneshot_ms_reg;
    logic [CFG_W-1:0] half_period_ms_reg;
    logic             wr_en;
    logic             reg_sel;

    // Word select: the register index is the byte address divided by four.
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oneshot_ms_reg     <= ONESHOT_MS_RST;
            half_period_ms_reg <= HALF_PERIOD_MS_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_ONESHOT_MS:     oneshot_ms_reg     <= pwdata[CFG_W-1:0];
                REG_HALF_PERIOD_MS: half_period_ms_reg <= pwdata[CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read back, zero extended.
    always_comb
    begin
        case (reg_sel)
            REG_ONESHOT_MS:     prdata = {{(APB_DATA_W-CFG_W){1'b0}}, oneshot_ms_reg};
            REG_HALF_PERIOD_MS: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, half_period_ms_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.oneshot_ms     = oneshot_ms_reg;
    assign cfg.half_period_ms = half_period_ms_reg;

endmodule

// ===== sv/lbo_cmd_reg.sv =====
// Input register stage that captures one command request per cycle while it is empty or drains.
`timescale 1ns / 1ps

module lbo_cmd_reg (
    input  logic           clk,
    input  logic           rst_n,
    lbo_cmd_if.sink        cmd,
    output logic           stg_valid,
    input  logic           stg_take,
    output lbo_pkg::cmd_t  stg_cmd
);
    import lbo_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;

    // A new request is taken when the stage is empty or drains this cycle.
    assign cmd.ready  = !valid_reg || stg_take;
    assign valid_next = cmd.valid || (valid_reg && !stg_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.func       <= cmd.func;
            cmd_reg.lamp_index <= cmd.lamp_index;
            cmd_reg.oneshot    <= cmd.oneshot;
        end
    end

    assign stg_valid = valid_reg;
    assign stg_cmd   = cmd_reg;

endmodule

// ===== sv/lbo_lamp_core.sv =====
// Lamp state, millisecond time base and the registered lamp state result.
`timescale 1ns / 1ps

module lbo_lamp_core (
    input  logic           clk,
    input  logic           rst_n,
    input  lbo_pkg::cfg_t  cfg,
    input  logic           stg_valid,
    output logic           stg_take,
    input  lbo_pkg::cmd_t  stg_cmd,
    lbo_res_if.source      res
);
    import lbo_pkg::*;

    logic [NUM_LAMPS-1:0] blinking_reg, blinking_next;
    logic [NUM_LAMPS-1:0] armed_reg, armed_next;
    logic [NUM_LAMPS-1:0] lit_reg, lit_next;
    logic [TIME_W-1:0]    deadline_reg [NUM_LAMPS];
    logic [TIME_W-1:0]    deadline_next [NUM_LAMPS];
    logic [TIME_W-1:0]    now_ms_reg, now_ms_next;
    logic [TIME_W-1:0]    last_toggle_reg, last_toggle_next;
    logic                 phase_reg, phase_next;
    logic                 out_valid_reg, out_valid_next;
    logic [LAMP_W-1:0]    out_lamps_reg, out_lamps_next;

    logic [TIME_W-1:0]    now_inc;
    logic [TIME_W-1:0]    toggle_at;
    logic [TIME_W-1:0]    shot_deadline;
    logic                 toggle_hit;
    logic [NUM_LAMPS-1:0] hit;

    // The request is applied when the result register is free or drains.
    assign stg_take = stg_valid && (!out_valid_reg || res.ready);

    // Time arithmetic shared by all lamps.
    assign now_inc       = now_ms_reg + 32'd1;
    assign toggle_at     = last_toggle_reg + {{(TIME_W-CFG_W){1'b0}}, cfg.half_period_ms};
    assign toggle_hit    = now_inc > toggle_at;
    assign shot_deadline = now_ms_reg + {{(TIME_W-CFG_W){1'b0}}, cfg.oneshot_ms};

    // Lamp addressed by an on, off or blink request.
    always_comb
    begin
        for (int i = 0; i < NUM_LAMPS; i++)
        begin
            hit[i] = (stg_cmd.lamp_index == LAMP_IDX_W'(i));
        end
    end

    // Next lamp and time state for the request being applied.
    always_comb
    begin
        blinking_next    = blinking_reg;
        armed_next       = armed_reg;
        lit_next         = lit_reg;
        deadline_next    = deadline_reg;
        now_ms_next      = now_ms_reg;
        last_toggle_next = last_toggle_reg;
        phase_next       = phase_reg;
        if (stg_take)
        begin
            case (stg_cmd.func)
                FUNC_ON:
                begin
                    blinking_next = blinking_reg & ~hit;
                    lit_next      = lit_reg | hit;
                end
                FUNC_OFF:
                begin
                    blinking_next = blinking_reg & ~hit;
                    lit_next      = lit_reg & ~hit;
                end
                FUNC_BLINK:
                begin
                    blinking_next = blinking_reg | hit;
                    if (stg_cmd.oneshot)
                    begin
                        armed_next = armed_reg | hit;
                        lit_next   = lit_reg | hit;
                        for (int i = 0; i < NUM_LAMPS; i++)
                        begin
                            if (hit[i])
                            begin
                                deadline_next[i] = shot_deadline;
                            end
                        end
                    end
                end
                FUNC_TICK:
                begin
                    now_ms_next = now_inc;
                    // Expire one-shot lamps whose deadline is now past.
                    for (int i = 0; i < NUM_LAMPS; i++)
                    begin
                        if (blinking_reg[i] && armed_reg[i] && (deadline_reg[i] < now_inc))
                        begin
                            lit_next[i]      = 1'b0;
                            armed_next[i]    = 1'b0;
                            blinking_next[i] = 1'b0;
                            deadline_next[i] = '0;
                        end
                    end
                    // Shared phase toggle drives every blinking, unarmed lamp.
                    if (toggle_hit)
                    begin
                        phase_next       = !phase_reg;
                        last_toggle_next = now_inc;
                        for (int i = 0; i < NUM_LAMPS; i++)
                        begin
                            if (blinking_next[i] && !armed_next[i])
                            begin
                                lit_next[i] = !phase_reg;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register contents.
    always_comb
    begin
        out_valid_next = out_valid_reg && !res.ready;
        out_lamps_next = out_lamps_reg;
        if (stg_take)
        begin
            out_valid_next = 1'b1;
            for (int i = 0; i < LAMP_W; i++)
            begin
                out_lamps_next[i] = (i < NUM_LAMPS) ? lit_next[i % NUM_LAMPS] : 1'b0;
            end
        end
    end

    // Control and lamp state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blinking_reg    <= '0;
            armed_reg       <= '0;
            lit_reg         <= '0;
            now_ms_reg      <= '0;
            last_toggle_reg <= '0;
            phase_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            blinking_reg    <= blinking_next;
            armed_reg       <= armed_next;
            lit_reg         <= lit_next;
            now_ms_reg      <= now_ms_next;
            last_toggle_reg <= last_toggle_next;
            phase_reg       <= phase_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Deadlines are only read while armed, so they need no reset.
    always_ff @(posedge clk)
    begin
        deadline_reg  <= deadline_next;
        out_lamps_reg <= out_lamps_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.lamp_states = out_lamps_reg;

    // State only moves when a request is applied.
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !stg_take |=> $stable(lit_reg) && $stable(now_ms_reg) && $stable(phase_reg))
        else $error("lamp state changed without a request");

    // A tick advances the millisecond count by exactly one.
    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_take && stg_cmd.func == FUNC_TICK) |=> now_ms_reg == $past(now_ms_reg) + 32'd1)
        else $error("tick did not advance the millisecond count");

    // The result presented matches the lamp state left by the request.
    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        stg_take |=> out_valid_reg && (out_lamps_reg[NUM_LAMPS-1:0] == lit_reg))
        else $error("result does not match lamp state");

endmodule

// ===== sv/led_blink_oneshot_controller.sv =====
// Top level of the LED blink controller with one-shot flashes.
//
//   Channel  Dir  Handshake         Payload
//   cmd      in   valid/ready       func, lamp_index, oneshot
//   res      out  valid/ready       lamp_states
//   apb      in   psel/penable      two 16-bit registers at byte 0 and 4
//
// One command request is accepted every cycle while cmd.ready is high; its result
// passes through the input register and then the result register before it is
// presented on res.
// All lamps are updated in parallel in the single pass between those registers.
// Reset is immediate: no clearing pass, the block accepts requests right after it.
// When res stalls the result register holds, and the input register still
// absorbs one more request before cmd.ready drops.
`timescale 1ns / 1ps

module led_blink_oneshot_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    lbo_cmd_if.sink                        cmd,
    lbo_res_if.source                      res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lbo_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lbo_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lbo_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lbo_pkg::*;

    cfg_t cfg;
    cmd_t stg_cmd;
    logic stg_valid;
    logic stg_take;

    // Configuration registers.
    lbo_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register.
    lbo_cmd_reg u_cmd (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stg_valid (stg_valid),
        .stg_take  (stg_take),
        .stg_cmd   (stg_cmd)
    );

    // Lamp state update and result register.
    lbo_lamp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .stg_valid (stg_valid),
        .stg_take  (stg_take),
        .stg_cmd   (stg_cmd),
        .res       (res)
    );

endmodule
